>>> rtl/core/emergency_history_ring_top_defines.svh
// ----------------------------------------------------------------------------
// Emergency history ring assertion macros
// Shared concurrent assertion forms, clocked on clk with arst_n as disable.
// ----------------------------------------------------------------------------
`ifndef EMERGENCY_HISTORY_RING_TOP_DEFINES_SVH
`define EMERGENCY_HISTORY_RING_TOP_DEFINES_SVH

// Plain property checked every clock outside reset.
`define EHR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define EHR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/ehr_pkg.sv
// ----------------------------------------------------------------------------
// Emergency history ring package
// Sizes, request opcodes and result status codes.
// ----------------------------------------------------------------------------
package ehr_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = 5;
	localparam int SUB_W  = 8;
	localparam int CODE_W = 16;
	localparam int WVAL_W = 8;
	localparam int DATA_W = 32;
	localparam int SLOT_W = CNT_W + 1;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_READ_ERR  = 2'd1,
		ST_WRITE_NA  = 2'd2,
		ST_RANGE_ERR = 2'd3
	} status_t;

endpackage

>>> rtl/core/emergency_history_ring_top.sv
// ----------------------------------------------------------------------------
// Emergency history ring
// Circular error history in a 16 x 32 synchronous RAM, newest-first readout.
// ----------------------------------------------------------------------------
// Usage:
//  - A request is taken at a rising edge with start high and busy low. busy is
//    never raised: one request may be issued every cycle.
//  - op selects add (store error_code, extra_info on top when info_valid),
//    read of sub_index, or write (only sub_index 0, write_value 0: clear).
//  - Each request gives one result: done high with read_data and status. The
//    RAM read of the slot in the s1 stage and then the output register lie
//    between the request and its result.
//  - Results cannot be held off; the receiver must take them when done is high.
//  - Ring pointer and count update at the request edge, so a request in the
//    next cycle already sees the new history.
//  - cfg_wr_en/cfg_wr_data write hist_len and restart the history; the user
//    writes only while no result is pending, the block does not enforce it.
//  - Reset: hist_len is 16, history empty. Per-slot valid bits clear at once,
//    so no RAM clearing pass is needed.
// ----------------------------------------------------------------------------
`include "emergency_history_ring_top_defines.svh"

module emergency_history_ring_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   op,
	input  logic [ehr_pkg::SUB_W-1:0]    sub_index,
	input  logic [ehr_pkg::CODE_W-1:0]   error_code,
	input  logic                         info_valid,
	input  logic [ehr_pkg::CODE_W-1:0]   extra_info,
	input  logic [ehr_pkg::WVAL_W-1:0]   write_value,
	input  logic                         cfg_wr_en,
	input  logic [ehr_pkg::CNT_W-1:0]    cfg_wr_data,
	output logic                         done,
	output logic [ehr_pkg::DATA_W-1:0]   read_data,
	output logic [1:0]                   status
);

	logic [ehr_pkg::DATA_W-1:0] mem [ehr_pkg::DEPTH];

	logic [ehr_pkg::CNT_W-1:0]  hist_len_q;
	logic [ehr_pkg::CNT_W-1:0]  newest_q;
	logic [ehr_pkg::CNT_W-1:0]  count_q;
	logic [ehr_pkg::DEPTH-1:0]  valid_q;

	logic                       vld_s1;
	logic                       rd_mem_s1;
	logic                       ent_vld_s1;
	logic [ehr_pkg::DATA_W-1:0] mem_rd_s1;
	logic [ehr_pkg::DATA_W-1:0] data_s1;
	ehr_pkg::status_t           status_s1;

	logic                       done_q;
	logic [ehr_pkg::DATA_W-1:0] read_data_q;
	ehr_pkg::status_t           status_q;

	logic                       accept;
	ehr_pkg::op_t               op_w;
	logic [ehr_pkg::CNT_W-1:0]  len;
	logic [ehr_pkg::CNT_W-1:0]  next_slot;
	logic [ehr_pkg::IDX_W-1:0]  waddr;
	logic [ehr_pkg::DATA_W-1:0] wword;
	logic                       do_add;
	logic                       do_clear;
	logic [ehr_pkg::CNT_W-1:0]  sub_lo;
	logic [ehr_pkg::SLOT_W-1:0] slot;
	logic [ehr_pkg::SLOT_W-1:0] slot_m1;
	logic [ehr_pkg::IDX_W-1:0]  raddr;
	logic                       slot_ok;
	logic                       rd_mem;
	logic [ehr_pkg::DATA_W-1:0] data_w;
	ehr_pkg::status_t           status_w;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign op_w   = ehr_pkg::op_t'(op);

	assign len = (hist_len_q > ehr_pkg::CNT_W'(ehr_pkg::DEPTH)) ?
		ehr_pkg::CNT_W'(ehr_pkg::DEPTH) : hist_len_q;

	always_comb begin
		next_slot = newest_q + ehr_pkg::CNT_W'(1);
		if (next_slot > len || next_slot == '0) begin
			next_slot = ehr_pkg::CNT_W'(1);
		end
	end

	assign waddr = ehr_pkg::IDX_W'(next_slot - ehr_pkg::CNT_W'(1));
	assign wword = {info_valid ? extra_info : {ehr_pkg::CODE_W{1'b0}}, error_code};

	// newest-first slot, 1-based
	assign sub_lo = sub_index[ehr_pkg::CNT_W-1:0];
	always_comb begin
		if (sub_index <= ehr_pkg::SUB_W'(newest_q)) begin
			slot = ehr_pkg::SLOT_W'(newest_q) + ehr_pkg::SLOT_W'(1)
				- ehr_pkg::SLOT_W'(sub_lo);
		end else begin
			slot = ehr_pkg::SLOT_W'(len) + ehr_pkg::SLOT_W'(newest_q)
				+ ehr_pkg::SLOT_W'(1) - ehr_pkg::SLOT_W'(sub_lo);
		end
	end
	assign slot_m1 = slot - ehr_pkg::SLOT_W'(1);
	assign raddr   = slot_m1[ehr_pkg::IDX_W-1:0];
	assign slot_ok = (slot >= ehr_pkg::SLOT_W'(1)) &&
		(slot <= ehr_pkg::SLOT_W'(ehr_pkg::DEPTH));

	always_comb begin
		do_add   = 1'b0;
		do_clear = 1'b0;
		rd_mem   = 1'b0;
		data_w   = '0;
		status_w = ehr_pkg::ST_OK;
		case (op_w)
			ehr_pkg::OP_ADD: begin
				do_add = (len != '0);
			end
			ehr_pkg::OP_READ: begin
				if (sub_index == '0) begin
					data_w = ehr_pkg::DATA_W'(count_q);
				end else if (sub_index <= ehr_pkg::SUB_W'(count_q)) begin
					rd_mem = slot_ok;
				end else if (sub_index > ehr_pkg::SUB_W'(len)) begin
					status_w = ehr_pkg::ST_READ_ERR;
				end
			end
			ehr_pkg::OP_WRITE: begin
				if (sub_index != '0) begin
					status_w = ehr_pkg::ST_WRITE_NA;
				end else if (write_value != '0) begin
					status_w = ehr_pkg::ST_RANGE_ERR;
				end else begin
					do_clear = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_len_q <= ehr_pkg::CNT_W'(ehr_pkg::DEPTH);
			newest_q   <= '0;
			count_q    <= '0;
			valid_q    <= '0;
		end else if (cfg_wr_en) begin
			hist_len_q <= cfg_wr_data;
			newest_q   <= '0;
			count_q    <= '0;
			valid_q    <= '0;
		end else if (accept && do_clear) begin
			newest_q <= '0;
			count_q  <= '0;
			valid_q  <= '0;
		end else if (accept && do_add) begin
			newest_q       <= next_slot;
			valid_q[waddr] <= 1'b1;
			if (count_q < len) begin
				count_q <= count_q + ehr_pkg::CNT_W'(1);
			end else begin
				count_q <= len;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && do_add && !cfg_wr_en) begin
			mem[waddr] <= wword;
		end
		if (accept && rd_mem) begin
			mem_rd_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_mem_s1  <= rd_mem;
			ent_vld_s1 <= valid_q[raddr];
			data_s1    <= data_w;
			status_s1  <= status_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			read_data_q <= rd_mem_s1 ? (ent_vld_s1 ? mem_rd_s1 : '0) : data_s1;
			status_q    <= status_s1;
		end
	end

	assign done      = done_q;
	assign read_data = read_data_q;
	assign status    = status_q;

	`EHR_ASSERT(a_count_bound, count_q <= ehr_pkg::CNT_W'(ehr_pkg::DEPTH), "count above depth")
	`EHR_ASSERT(a_newest_le_count, newest_q <= count_q, "newest slot beyond count")
	`EHR_ASSERT_NEXT(a_result_follows, vld_s1, done, "result strobe missing")
	`EHR_ASSERT(a_rderr_zero, !(done && status == ehr_pkg::ST_READ_ERR) || read_data == '0, "read error with data")

endmodule
